[rtl/fbs_pkg.sv]
package fbs_pkg;

    localparam int unsigned BlockBytes   = 16;
    localparam int unsigned DataW        = 8 * BlockBytes;
    localparam int unsigned SumW         = 8;
    localparam int unsigned InTdataW     = DataW;
    localparam int unsigned OutTdataW    = DataW + SumW;
    localparam int unsigned DefGroupBlks = 32;
    localparam int unsigned RotBytes     = 4;

    typedef logic [BlockBytes-1:0][7:0] t_block;

    localparam t_block KEY = {
        8'h61, 8'h74, 8'h73, 8'h4d, 8'h84, 8'h25, 8'h46, 8'ha3,
        8'h4e, 8'h35, 8'h6b, 8'h49, 8'h43, 8'hc4, 8'h36, 8'h7a
    };

endpackage

[rtl/fbs_lanes.sv]
module fbs_lanes (
    input  logic           i_encode,
    input  fbs_pkg::t_block i_src,
    input  fbs_pkg::t_block i_chain,
    output fbs_pkg::t_block o_res,
    output fbs_pkg::t_block o_chain_next,
    output logic [7:0]     o_plain_sum
);
    import fbs_pkg::*;

    t_block     keyed;
    t_block     plain;
    logic [7:0] s8 [8];
    logic [7:0] s4 [4];
    logic [7:0] s2 [2];

    always_comb begin
        for (int i = 0; i < BlockBytes; i++) begin
            if (i_encode) begin
                keyed[i] = i_src[(i + BlockBytes - RotBytes) % BlockBytes] ^ i_chain[i];
                o_res[i] = keyed[i] ^ KEY[i];
                plain[i] = i_src[i];
            end else begin
                keyed[i] = i_src[i] ^ KEY[i];
                plain[i] = keyed[i] ^ i_chain[i];
                o_res[i] = 8'h00;
            end
        end
        if (!i_encode) begin
            for (int j = 0; j < BlockBytes; j++) begin
                o_res[j] = plain[(j + RotBytes) % BlockBytes];
            end
        end
        o_chain_next = keyed;
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s8[i] = plain[2*i] + plain[2*i+1];
        end
        for (int i = 0; i < 4; i++) begin
            s4[i] = s8[2*i] + s8[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            s2[i] = s4[2*i] + s4[2*i+1];
        end
        o_plain_sum = s2[0] + s2[1];
    end

endmodule

[rtl/firmware_block_scrambler_top.sv]
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle unless output stalls; chain updated once per word.
// The input register takes a new word whenever the result register is free or drains.
// Reset is synchronous and active low; it clears the valid flags, the mode,
// the chain bytes, the block count and the running sum.
module firmware_block_scrambler_top #(
    parameter int unsigned GROUP_BLOCKS = fbs_pkg::DefGroupBlks
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: data_low, data_high.
    input  logic [fbs_pkg::InTdataW-1:0]   i_s_tdata,
    // Fields from bit 0: restart.
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // Fields from bit 0: out_low, out_high, checksum.
    output logic [fbs_pkg::OutTdataW-1:0]  o_m_tdata,
    // Fields from bit 0: checksum_valid.
    output logic                           o_m_tuser
);
    import fbs_pkg::*;

    localparam int unsigned IdxW = (GROUP_BLOCKS > 1) ? $clog2(GROUP_BLOCKS) : 1;

    logic                 r_mode;
    logic                 r_s1_valid;
    t_block               r_s1_data;
    logic                 r_s1_restart;
    logic                 r_m_valid;
    logic [OutTdataW-1:0] r_m_data;
    logic                 r_m_csv;
    t_block               r_chain;
    logic [IdxW-1:0]      r_idx;
    logic [SumW-1:0]      r_sum;

    logic                 adv;
    logic                 s_ready;
    t_block               chain_use;
    logic [IdxW-1:0]      idx_use;
    logic [SumW-1:0]      sum_use;
    t_block               res;
    t_block               chain_next;
    logic [SumW-1:0]      plain_sum;
    logic [SumW-1:0]      n_sum;
    logic                 closes;

    assign adv     = r_s1_valid && (!r_m_valid || i_m_tready);
    assign s_ready = !r_s1_valid || adv;

    assign chain_use = r_s1_restart ? '0 : r_chain;
    assign idx_use   = r_s1_restart ? '0 : r_idx;
    assign sum_use   = r_s1_restart ? '0 : r_sum;
    assign n_sum     = sum_use + plain_sum;
    assign closes    = (idx_use == IdxW'(GROUP_BLOCKS - 1));

    fbs_lanes u_lanes (
        .i_encode     (r_mode),
        .i_src        (r_s1_data),
        .i_chain      (chain_use),
        .o_res        (res),
        .o_chain_next (chain_next),
        .o_plain_sum  (plain_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_chain    <= '0;
            r_idx      <= '0;
            r_sum      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (s_ready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_m_valid <= 1'b1;
                if (closes) begin
                    r_chain <= '0;
                    r_idx   <= '0;
                    r_sum   <= '0;
                end else begin
                    r_chain <= chain_next;
                    r_idx   <= idx_use + IdxW'(1);
                    r_sum   <= n_sum;
                end
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_s1_data    <= i_s_tdata;
            r_s1_restart <= i_s_tuser;
        end
        if (adv) begin
            r_m_data <= {(closes ? n_sum : '0), res};
            r_m_csv  <= closes;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_csv;

endmodule

[rtl/fbs_checker.sv]
module fbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [fbs_pkg::OutTdataW-1:0] o_m_tdata,
    input logic                          o_m_tuser
);
    import fbs_pkg::*;

    // A stalled result word keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // The checksum byte is zero unless the word closes a group.
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[OutTdataW-1:DataW] == '0)
        else $error("checksum byte set on a word that does not close a group");

    // No result word is shown in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind firmware_block_scrambler_top fbs_checker u_fbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
